// File: design/ark4_pkg.sv
// Shared types, constants and helpers for the Ackermann RK4 derivative pipeline.
package ark4_pkg;

    // configuration register indexes
    localparam logic CFG_STEP_TIME = 1'b0;
    localparam logic CFG_INV_WB    = 1'b1;

    localparam logic [16:0] STEP_TIME_RST = 17'd6554;
    localparam logic [20:0] INV_WB_RST    = 21'd21845;

    // angle reduction: 2*pi and pi in Q16.16, reciprocal of the Q16.16 value of 2*pi scaled by 2^51
    localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
    localparam logic [18:0] PI_Q16     = 19'd205887;
    localparam logic [32:0] RED_MUL    = 33'd5468519977;
    localparam int          RED_SHIFT  = 51;
    // (2*pi - (2^31 mod 2*pi)) undoes the +2^31 offset of the unsigned angle
    localparam logic [18:0] RED_OFFS   = 19'd334752;

    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    // ceil(2^34 / 6)
    localparam logic [31:0] DIV6_MUL = 32'd2863311531;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
        30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
    };

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               neg;
    } t_rot;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] low;
        logic [32:0] ac;
        logic [31:0] q;
        logic        neg;
        logic        ovf;
    } t_div;

    // original state and running weighted sums that ride along each round
    typedef struct packed {
        logic signed [31:0] v0;
        logic signed [31:0] th0;
        logic signed [31:0] d0;
        logic signed [31:0] a;
        logic signed [31:0] r;
        logic signed [34:0] acc_x;
        logic signed [34:0] acc_y;
        logic signed [34:0] acc_th;
    } t_side;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return S32_MAX;
        end
        if (v < -66'sd2147483648) begin
            return S32_MIN;
        end
        return v[31:0];
    endfunction

endpackage

// File: design/ark4_cordic_cell.sv
// One CORDIC rotation iteration with its output register.
module ark4_cordic_cell import ark4_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_rot i_rot,
    output t_rot o_rot
);

    logic signed [33:0] w_atan;
    t_rot               n_rot;
    t_rot               r_rot;

    assign w_atan = $signed(34'(ATAN_Q30[5'(IDX)]));

    always_comb begin
        n_rot = i_rot;
        if (!i_rot.z[33]) begin
            n_rot.x = i_rot.x - (i_rot.y >>> IDX);
            n_rot.y = i_rot.y + (i_rot.x >>> IDX);
            n_rot.z = i_rot.z - w_atan;
        end else begin
            n_rot.x = i_rot.x + (i_rot.y >>> IDX);
            n_rot.y = i_rot.y - (i_rot.x >>> IDX);
            n_rot.z = i_rot.z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule

// File: design/ark4_div_cell.sv
// One restoring-division step: resolves one quotient bit, registered.
module ark4_div_cell import ark4_pkg::*; #(
    parameter int BIT = 31
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_div,
    output t_div o_div
);

    logic [33:0] w_rem2;
    t_div        n_div;
    t_div        r_div;

    assign w_rem2 = {i_div.rem, i_div.low[BIT]};

    always_comb begin
        n_div = i_div;
        if (w_rem2 >= {1'b0, i_div.ac}) begin
            n_div.rem    = 33'(w_rem2 - {1'b0, i_div.ac});
            n_div.q[BIT] = 1'b1;
        end else begin
            n_div.rem = w_rem2[32:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

// File: design/ark4_eval.sv
// One pipelined bicycle-model derivative evaluation (dx, dy, dtheta).
module ark4_eval import ark4_pkg::*; #(
    parameter int CORDIC_ITERS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [31:0] i_v,
    input  logic signed [31:0] i_th,
    input  logic signed [31:0] i_d,
    input  t_side              i_side,
    input  logic [20:0]        i_inv_wb,
    output logic               o_vld,
    output t_side              o_side,
    output logic signed [31:0] o_dx,
    output logic signed [31:0] o_dy,
    output logic signed [31:0] o_dth
);

    localparam int N   = CORDIC_ITERS;
    localparam int LAT = N + 43;

    // index 0: heading, index 1: steering angle
    logic [31:0]        w_u    [2];
    logic [64:0]        r_prod [2];
    logic [31:0]        r_u    [2];
    logic [19:0]        r_rem  [2];
    logic [18:0]        r_fm   [2];
    t_rot               r_rot0 [2];
    t_rot               w_rot  [2][N+1];
    logic signed [33:0] r_sn   [2];
    logic signed [33:0] r_cs   [2];

    logic signed [65:0] r_pc, r_ps;
    t_div               r_dv0;
    t_div               w_dv [33];
    logic signed [31:0] r_t;
    logic signed [63:0] r_pt;
    logic signed [31:0] r_vt;
    logic signed [53:0] r_pw;
    logic signed [31:0] r_dth;
    logic signed [31:0] r_dx [37];
    logic signed [31:0] r_dy [37];
    logic signed [31:0] r_v  [N+39];
    t_side              r_side [LAT];
    logic               r_vld  [LAT];

    assign w_u[0] = {~i_th[31], i_th[30:0]};
    assign w_u[1] = {~i_d[31], i_d[30:0]};

    // range reduction to [-pi, pi], scale to Q2.30 and fold into [-pi/2, pi/2]
    logic [18:0]        w_r1 [2];
    logic [19:0]        w_m  [2];
    logic [18:0]        n_fm [2];
    logic signed [19:0] w_c  [2];
    logic signed [33:0] w_z  [2];
    t_rot               n_rot0 [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_r1[a] = (r_rem[a] >= 20'(TWO_PI_Q16)) ? 19'(r_rem[a] - 20'(TWO_PI_Q16))
                                                    : r_rem[a][18:0];
            w_m[a]  = 20'(w_r1[a]) + 20'(RED_OFFS);
            n_fm[a] = (w_m[a] >= 20'(TWO_PI_Q16)) ? 19'(w_m[a] - 20'(TWO_PI_Q16))
                                                  : w_m[a][18:0];
            w_c[a]  = (r_fm[a] > PI_Q16) ? $signed({1'b0, r_fm[a]}) - 20'sd411775
                                         : $signed({1'b0, r_fm[a]});
            w_z[a]  = $signed({w_c[a], 14'd0});
            n_rot0[a].x   = GAIN_Q30;
            n_rot0[a].y   = '0;
            n_rot0[a].z   = w_z[a];
            n_rot0[a].neg = 1'b0;
            if (w_z[a] > HALF_PI_Q30) begin
                n_rot0[a].z   = w_z[a] - PI_Q30;
                n_rot0[a].neg = 1'b1;
            end else if (w_z[a] < -HALF_PI_Q30) begin
                n_rot0[a].z   = w_z[a] + PI_Q30;
                n_rot0[a].neg = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 2; a++) begin
                r_prod[a] <= 65'(w_u[a]) * 65'(RED_MUL);
                r_u[a]    <= w_u[a];
                r_rem[a]  <= 20'(33'(r_u[a]) - 33'(r_prod[a][64:RED_SHIFT])
                                 * 33'(TWO_PI_Q16));
                r_fm[a]   <= n_fm[a];
                r_rot0[a] <= n_rot0[a];
                r_sn[a]   <= w_rot[a][N].neg ? -w_rot[a][N].y : w_rot[a][N].y;
                r_cs[a]   <= w_rot[a][N].neg ? -w_rot[a][N].x : w_rot[a][N].x;
            end
        end
    end

    for (genvar a = 0; a < 2; a++) begin : g_ang
        assign w_rot[a][0] = r_rot0[a];
        for (genvar i = 0; i < N; i++) begin : g_rot
            ark4_cordic_cell #(.IDX(i)) u_cell (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_rot (w_rot[a][i]),
                .o_rot (w_rot[a][i+1])
            );
        end
    end

    // tangent: |sin| * 2^16 / |cos|, quotient of 2^32 or more saturates
    logic [32:0] w_as, w_ac;
    t_div        n_dv0;

    always_comb begin
        w_as = r_sn[1][33] ? 33'(-r_sn[1]) : 33'(r_sn[1]);
        w_ac = r_cs[1][33] ? 33'(-r_cs[1]) : 33'(r_cs[1]);
        n_dv0.rem = 33'(w_as[32:16]);
        n_dv0.low = {w_as[15:0], 16'd0};
        n_dv0.ac  = w_ac;
        n_dv0.q   = '0;
        n_dv0.neg = r_sn[1][33] ^ r_cs[1][33];
        n_dv0.ovf = {16'd0, w_as} >= {w_ac, 16'd0};
    end

    assign w_dv[0] = r_dv0;
    for (genvar i = 0; i < 32; i++) begin : g_div
        ark4_div_cell #(.BIT(31 - i)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_div (w_dv[i]),
            .o_div (w_dv[i+1])
        );
    end

    logic signed [31:0] n_t;

    always_comb begin
        if (w_dv[32].ovf) begin
            n_t = w_dv[32].neg ? S32_MIN : S32_MAX;
        end else if (w_dv[32].neg) begin
            n_t = (w_dv[32].q > 32'h8000_0000) ? S32_MIN : -$signed(w_dv[32].q);
        end else begin
            n_t = (w_dv[32].q > 32'h7fff_ffff) ? S32_MAX : $signed(w_dv[32].q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc  <= 66'(r_v[N+4]) * 66'(r_cs[0]);
            r_ps  <= 66'(r_v[N+4]) * 66'(r_sn[0]);
            r_dv0 <= n_dv0;
            r_t   <= n_t;
            r_pt  <= 64'(r_v[N+38]) * 64'(r_t);
            r_vt  <= sat32(66'(r_pt >>> 16));
            r_pw  <= 54'(r_vt) * 54'($signed({1'b0, i_inv_wb}));
            r_dth <= sat32(66'(r_pw >>> 16));
            r_dx[0] <= sat32(r_pc >>> 30);
            r_dy[0] <= sat32(r_ps >>> 30);
            for (int k = 1; k < 37; k++) begin
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
            end
            r_v[0] <= i_v;
            for (int k = 1; k < N + 39; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_side[0] <= i_side;
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_vld  = r_vld[LAT-1];
    assign o_side = r_side[LAT-1];
    assign o_dx   = r_dx[36];
    assign o_dy   = r_dy[36];
    assign o_dth  = r_dth;

endmodule

// File: design/ackermann_rk4_step_unit.sv
// Ackermann RK4 step unit: four chained derivative evaluations and the 1-2-2-1 average.
// Fully pipelined: takes one state/control item per clock unless backpressure stalls it,
// and returns the averaged RK4 derivative of each item. Each of the four evaluations is a
// row of CORDIC cells (one per iteration, sine/cosine of heading and of steering angle side
// by side) followed by a row of 32 divider cells for the tangent and the speed and wheelbase
// multiplies; product and sum registers advance the state between rounds. Backpressure
// stalls the whole row of cells only when the output register is full, not taken, and
// another result is ready behind it. The user must write step_time and inv_wheelbase
// through the register port only while no item is in flight; the block does not enforce it.
module ackermann_rk4_step_unit import ark4_pkg::*; #(
    parameter int CORDIC_ITERS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // pos_x, pos_y, speed, heading, steer_angle, accel, steer_rate (32 bits each)
    input  logic [223:0]  i_s_tdata,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // rate_x, rate_y, rate_speed, rate_heading, rate_steer (32 bits each)
    output logic [159:0]  o_m_tdata,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [20:0]   i_cfg_wdata
);

    logic [16:0] r_step_time;
    logic [20:0] r_inv_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= STEP_TIME_RST;
            r_inv_wb    <= INV_WB_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_TIME: r_step_time <= i_cfg_wdata[16:0];
                CFG_INV_WB:    r_inv_wb    <= i_cfg_wdata;
                default:       ;
            endcase
        end
    end

    logic w_en;
    logic r_o_vld;
    logic r_f3_vld;

    assign w_en       = !(r_o_vld && !i_m_tready && r_f3_vld);
    assign o_s_tready = w_en;

    t_side w_side_in;

    always_comb begin
        w_side_in.v0     = $signed(i_s_tdata[95:64]);
        w_side_in.th0    = $signed(i_s_tdata[127:96]);
        w_side_in.d0     = $signed(i_s_tdata[159:128]);
        w_side_in.a      = $signed(i_s_tdata[191:160]);
        w_side_in.r      = $signed(i_s_tdata[223:192]);
        w_side_in.acc_x  = '0;
        w_side_in.acc_y  = '0;
        w_side_in.acc_th = '0;
    end

    logic               w_ev_vld  [4];
    logic signed [31:0] w_ev_v    [4];
    logic signed [31:0] w_ev_th   [4];
    logic signed [31:0] w_ev_d    [4];
    t_side              w_ev_side [4];
    logic               w_k_vld   [4];
    t_side              w_k_side  [4];
    logic signed [31:0] w_kx      [4];
    logic signed [31:0] w_ky      [4];
    logic signed [31:0] w_kth     [4];
    logic               r_a1_vld  [4];
    t_side              r_a1_side [4];

    assign w_ev_vld[0]  = i_s_tvalid;
    assign w_ev_v[0]    = w_side_in.v0;
    assign w_ev_th[0]   = w_side_in.th0;
    assign w_ev_d[0]    = w_side_in.d0;
    assign w_ev_side[0] = w_side_in;

    for (genvar j = 0; j < 4; j++) begin : g_round
        localparam int SH = (j == 1 || j == 2) ? 1 : 0;

        t_side n_a1_side;

        ark4_eval #(.CORDIC_ITERS(CORDIC_ITERS)) u_eval (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_vld    (w_ev_vld[j]),
            .i_v      (w_ev_v[j]),
            .i_th     (w_ev_th[j]),
            .i_d      (w_ev_d[j]),
            .i_side   (w_ev_side[j]),
            .i_inv_wb (r_inv_wb),
            .o_vld    (w_k_vld[j]),
            .o_side   (w_k_side[j]),
            .o_dx     (w_kx[j]),
            .o_dy     (w_ky[j]),
            .o_dth    (w_kth[j])
        );

        // weighted accumulation: 1, 2, 2, 1
        always_comb begin
            n_a1_side        = w_k_side[j];
            n_a1_side.acc_x  = w_k_side[j].acc_x + (35'(w_kx[j]) <<< SH);
            n_a1_side.acc_y  = w_k_side[j].acc_y + (35'(w_ky[j]) <<< SH);
            n_a1_side.acc_th = w_k_side[j].acc_th + (35'(w_kth[j]) <<< SH);
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_a1_side[j] <= n_a1_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a1_vld[j] <= 1'b0;
            end else if (w_en) begin
                r_a1_vld[j] <= w_k_vld[j];
            end
        end

        if (j < 3) begin : g_adv
            logic [16:0]        w_hh;
            logic signed [49:0] r_p_th, r_p_v, r_p_d;
            logic signed [31:0] r_nv, r_nth, r_nd;
            t_side              r_a2_side;
            logic               r_a2_vld;

            // half step for the second and third evaluations, full step for the fourth
            assign w_hh = (j == 2) ? r_step_time : {1'b0, r_step_time[16:1]};

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_p_th    <= 50'(w_kth[j]) * 50'($signed({1'b0, w_hh}));
                    r_p_v     <= 50'(w_k_side[j].a) * 50'($signed({1'b0, w_hh}));
                    r_p_d     <= 50'(w_k_side[j].r) * 50'($signed({1'b0, w_hh}));
                    r_nv      <= sat32(66'(r_a1_side[j].v0) + 66'(r_p_v >>> 16));
                    r_nth     <= sat32(66'(r_a1_side[j].th0) + 66'(r_p_th >>> 16));
                    r_nd      <= sat32(66'(r_a1_side[j].d0) + 66'(r_p_d >>> 16));
                    r_a2_side <= r_a1_side[j];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_a2_vld <= 1'b0;
                end else if (w_en) begin
                    r_a2_vld <= r_a1_vld[j];
                end
            end

            assign w_ev_vld[j+1]  = r_a2_vld;
            assign w_ev_v[j+1]    = r_nv;
            assign w_ev_th[j+1]   = r_nth;
            assign w_ev_d[j+1]    = r_nd;
            assign w_ev_side[j+1] = r_a2_side;
        end
    end

    // divide the three sums by 6, truncating toward zero
    logic signed [34:0] w_acc [3];
    logic [33:0]        r_f1_mag [3];
    logic               r_f1_neg [3];
    logic [33:0]        r_f2_mag [3];
    logic [65:0]        r_f2_p   [3];
    logic               r_f2_neg [3];
    logic [31:0]        r_f3_q   [3];
    logic               r_f3_neg [3];
    t_side              r_f1_side, r_f2_side, r_f3_side;
    logic               r_f1_vld, r_f2_vld;
    logic [31:0]        w_qe     [3];
    logic [31:0]        w_q      [3];
    logic signed [31:0] w_avg    [3];

    assign w_acc[0] = r_a1_side[3].acc_x;
    assign w_acc[1] = r_a1_side[3].acc_y;
    assign w_acc[2] = r_a1_side[3].acc_th;

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            w_qe[n] = r_f2_p[n][65:34];
            w_q[n]  = (35'(w_qe[n]) * 35'd6 > 35'(r_f2_mag[n])) ? w_qe[n] - 32'd1 : w_qe[n];
            if (r_f3_neg[n]) begin
                w_avg[n] = (r_f3_q[n] > 32'h8000_0000) ? S32_MIN : -$signed(r_f3_q[n]);
            end else begin
                w_avg[n] = (r_f3_q[n] > 32'h7fff_ffff) ? S32_MAX : $signed(r_f3_q[n]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int n = 0; n < 3; n++) begin
                r_f1_mag[n] <= w_acc[n][34] ? 34'(-w_acc[n]) : 34'(w_acc[n]);
                r_f1_neg[n] <= w_acc[n][34];
                r_f2_p[n]   <= 66'(r_f1_mag[n]) * 66'(DIV6_MUL);
                r_f2_mag[n] <= r_f1_mag[n];
                r_f2_neg[n] <= r_f1_neg[n];
                r_f3_q[n]   <= w_q[n];
                r_f3_neg[n] <= r_f2_neg[n];
            end
            r_f1_side <= r_a1_side[3];
            r_f2_side <= r_f1_side;
            r_f3_side <= r_f2_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
        end else if (w_en) begin
            r_f1_vld <= r_a1_vld[3];
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
        end
    end

    // output register: holds a result until its transfer
    logic [159:0] r_o_data;

    always_ff @(posedge i_clk) begin
        if (w_en && r_f3_vld) begin
            r_o_data <= {r_f3_side.r, w_avg[2], r_f3_side.a, w_avg[1], w_avg[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en && r_f3_vld) begin
            r_o_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_data;

endmodule

// File: verif/ackermann_rk4_step_unit_chk.sv
// Checker for the Ackermann RK4 step unit: predicts each result and compares the outputs.
module ackermann_rk4_step_unit_chk (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    // pos_x, pos_y, speed, heading, steer_angle, accel, steer_rate (32 bits each)
    input  logic [223:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // rate_x, rate_y, rate_speed, rate_heading, rate_steer (32 bits each)
    input  logic [159:0] i_m_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [20:0]  i_cfg_wdata,
    output int           o_errors,
    output int           o_pending
);
    import ark4_pkg::*;

    localparam int ROT_STEPS = 16;

    typedef struct {
        longint dx;
        longint dy;
        longint dth;
    } t_slope;

    longint arc_q30 [32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 7, 3, 1, 0, 0
    };

    logic [16:0]  dt_reg;
    logic [20:0]  iwb_reg;
    logic [159:0] rate_q [$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void sin_cos(input longint ang, output longint s, output longint c);
        longint r, x, y, z, nx;
        bit     flip;
        x = 652032874;
        y = 0;
        flip = 0;
        r = ang % 411775;
        if (r < 0) r += 411775;
        if (r > 205887) r -= 411775;
        z = r * 16384;
        if (z > 1686629713) begin
            z -= 64'sd3373259426;
            flip = 1;
        end else if (z < -1686629713) begin
            z += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arc_q30[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arc_q30[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic t_slope slope(input longint v, input longint th, input longint d);
        t_slope k;
        longint s, c, t, vt;
        sin_cos(th, s, c);
        k.dx = clamp32((v * c) >>> 30);
        k.dy = clamp32((v * s) >>> 30);
        sin_cos(d, s, c);
        if (c == 0) t = (s < 0) ? -64'sd2147483648 : 64'sd2147483647;
        else t = clamp32((s * 65536) / c);
        vt = clamp32((v * t) >>> 16);
        k.dth = clamp32((vt * longint'(iwb_reg)) >>> 16);
        return k;
    endfunction

    function automatic longint nudge(input longint s, input longint k, input longint h);
        return clamp32(s + ((k * h) >>> 16));
    endfunction

    function automatic longint blend(input longint a, b, c, d);
        return clamp32((a + 2 * b + 2 * c + d) / 6);
    endfunction

    function automatic logic [159:0] rk4_rates(input logic [223:0] st);
        longint v, th, d, a, r, dt, h;
        t_slope k1, k2, k3, k4;
        logic [159:0] o;
        v  = longint'(signed'(st[95:64]));
        th = longint'(signed'(st[127:96]));
        d  = longint'(signed'(st[159:128]));
        a  = longint'(signed'(st[191:160]));
        r  = longint'(signed'(st[223:192]));
        dt = longint'(dt_reg);
        h  = longint'(dt_reg >> 1);
        k1 = slope(v, th, d);
        k2 = slope(nudge(v, a, h), nudge(th, k1.dth, h), nudge(d, r, h));
        k3 = slope(nudge(v, a, h), nudge(th, k2.dth, h), nudge(d, r, h));
        k4 = slope(nudge(v, a, dt), nudge(th, k3.dth, dt), nudge(d, r, dt));
        o[31:0]    = 32'(blend(k1.dx, k2.dx, k3.dx, k4.dx));
        o[63:32]   = 32'(blend(k1.dy, k2.dy, k3.dy, k4.dy));
        o[95:64]   = 32'(blend(a, a, a, a));
        o[127:96]  = 32'(blend(k1.dth, k2.dth, k3.dth, k4.dth));
        o[159:128] = 32'(blend(r, r, r, r));
        return o;
    endfunction

    always @(posedge i_clk) begin
        logic [159:0] want;
        int           bad;
        bad = 0;
        if (!i_rst_n) begin
            dt_reg    <= STEP_TIME_RST;
            iwb_reg   <= INV_WB_RST;
            o_errors  <= 0;
            o_pending <= 0;
            rate_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) rate_q.push_back(rk4_rates(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (rate_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %h", i_m_tdata);
                    bad = 1;
                end else begin
                    want = rate_q.pop_front();
                    for (int f = 0; f < 5; f++) begin
                        if (want[f*32 +: 32] !== i_m_tdata[f*32 +: 32]) begin
                            if (o_errors + bad < 10)
                                $display("field %0d: expected %h got %h", f,
                                         want[f*32 +: 32], i_m_tdata[f*32 +: 32]);
                            bad++;
                        end
                    end
                end
            end
            o_errors  <= o_errors + bad;
            o_pending <= rate_q.size();
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_STEP_TIME) dt_reg <= i_cfg_wdata[16:0];
                else if (i_cfg_idx == CFG_INV_WB) iwb_reg <= i_cfg_wdata;
            end
        end
    end
endmodule

// File: verif/ackermann_rk4_step_unit_test.sv
// Testbench top for the Ackermann RK4 step unit: stimulus, handshake pacing and verdict.
module ackermann_rk4_step_unit_test;
    import ark4_pkg::*;

    localparam int STALL_LIMIT = 6000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [223:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [159:0] o_m_tdata;
    logic         i_cfg_we = 0;
    logic         i_cfg_idx = CFG_STEP_TIME;
    logic [20:0]  i_cfg_wdata = '0;
    logic         hold_req = 0;
    int           errors, pending, idle_cycles, burst_left;

    always #1 i_clk = ~i_clk;

    ackermann_rk4_step_unit u_top (.*);

    ackermann_rk4_step_unit_chk u_chk (
        .i_clk, .i_rst_n, .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_cfg_we, .i_cfg_idx, .i_cfg_wdata, .o_errors(errors), .o_pending(pending)
    );

    // no transfer on either side for too long means a hang
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, ready streaks, and one long hold-off to back up the pipe
    initial begin
        int cyc;
        bit held;
        cyc = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_req && !held) begin
                held = 1;
                i_m_tready <= 0;
                repeat (900) @(posedge i_clk);
                cyc++;
            end
            case ((cyc / 64) % 3)
                0: i_m_tready <= 1;
                1: i_m_tready <= ($urandom_range(0, 3) != 0);
                default: i_m_tready <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    task automatic send_state(input logic [223:0] d);
        logic rdy;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                i_s_tvalid <= 0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1;
        i_s_tdata  <= d;
        forever begin
            @(negedge i_clk);
            rdy = o_s_tready;
            @(posedge i_clk);
            if (rdy) break;
        end
    endtask

    task automatic write_reg(input logic idx, input logic [20:0] val);
        i_cfg_we    <= 1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_field(input int kind);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
            2: return 32'($urandom_range(0, 32'h000c_0000)) - 32'h0006_0000;
            default: return (kind == 4) ? 32'($urandom_range(102000, 103900)) *
                                          ($urandom_range(0, 1) ? 1 : -1)
                                        : 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [223:0] rand_state();
        logic [223:0] d;
        for (int f = 0; f < 7; f++) d[f*32 +: 32] = pick_field(f);
        return d;
    endfunction

    function automatic logic [223:0] all_fields(input logic [31:0] v);
        return {7{v}};
    endfunction

    initial begin
        logic [16:0] dt_set [6] = '{17'd0, 17'd1, 17'd65536, 17'd131071, 17'd32768, 17'd6554};
        logic [20:0] wb_set [6] = '{21'd0, 21'd1, 21'd1048576, 21'h1fffff, 21'd65536, 21'd21845};
        logic [223:0] d;
        burst_left = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // corner states at reset configuration
        send_state('0);
        send_state(all_fields(32'h7fff_ffff));
        send_state(all_fields(32'h8000_0000));
        send_state(all_fields(32'hffff_ffff));
        send_state(all_fields(32'h0001_0000));
        foreach (dt_set[i]) begin
            d = '0;
            d[95:64]   = 32'h0005_0000;
            d[127:96]  = 32'(i * 102944 - 205887);
            d[159:128] = 32'(102940 + i);
            d[191:160] = 32'h7fff_ffff;
            d[223:192] = 32'h8000_0000;
            send_state(d);
        end
        d = '0;
        d[95:64]   = 32'h7fff_ffff;
        d[159:128] = 32'd102944;
        send_state(d);
        d[159:128] = -32'd102944;
        send_state(d);
        d[127:96] = 32'd205887;
        send_state(d);
        d[127:96] = -32'd205888;
        send_state(d);
        // long receiver hold-off while this burst keeps offering items
        hold_req = 1;
        repeat (500) send_state(rand_state());
        drain();

        foreach (dt_set[p]) begin
            write_reg(CFG_STEP_TIME, 21'(dt_set[p]));
            write_reg(CFG_INV_WB, wb_set[p]);
            repeat (p == 5 ? 270 : 230) send_state(rand_state());
            drain();
        end

        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// File: filelist.f
design/ark4_pkg.sv
design/ark4_cordic_cell.sv
design/ark4_div_cell.sv
design/ark4_eval.sv
design/ackermann_rk4_step_unit.sv
verif/ackermann_rk4_step_unit_chk.sv
verif/ackermann_rk4_step_unit_test.sv
